FILE: rtl/tcw_pkg.sv
// shared types, codes and constants of the text console writer
package tcw_pkg;

	localparam int SCREEN_COLUMNS = 80;
	localparam int SCREEN_ROWS    = 25;

	localparam int CHAR_W   = 8;
	localparam int ATTR_W   = 8;
	localparam int CELL_W   = CHAR_W + ATTR_W;
	localparam int TAB_W    = 7;
	localparam int IDX_W    = 11;
	localparam int CFG_IDX_W = 1;
	localparam int CFG_DATA_W = 8;

	localparam logic [ATTR_W-1:0] RESET_ATTR = 8'h07;
	localparam logic [TAB_W-1:0]  RESET_TAB  = 7'd3;

	localparam logic [CHAR_W-1:0] CH_TAB = 8'h09;
	localparam logic [CHAR_W-1:0] CH_LF  = 8'h0A;
	localparam logic [CHAR_W-1:0] CH_CR  = 8'h0D;
	localparam logic [CHAR_W-1:0] CH_NUL = 8'h00;

	localparam logic OP_PUT  = 1'b0;
	localparam logic OP_READ = 1'b1;

	localparam logic [CFG_IDX_W-1:0] REG_TEXT_ATTR   = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_TAB_ADVANCE = 1'b1;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_EXEC,
		ST_COPY,
		ST_BLANK,
		ST_FIN
	} state_t;

	typedef struct packed {
		logic take;
		logic clear_step;
		logic exec;
		logic copy_step;
		logic blank_step;
		logic load_out;
	} cmd_t;

	typedef struct packed {
		logic clear_done;
		logic scroll;
		logic copy_done;
		logic blank_done;
	} sts_t;

endpackage

FILE: rtl/tcw_if.sv
// request and response channel interfaces of the text console writer
interface tcw_req_if;
	logic                         valid;
	logic                         ready;
	logic                         op;
	logic [tcw_pkg::CHAR_W-1:0]   char_code;
	logic [tcw_pkg::IDX_W-1:0]    cell_index;

	modport source (output valid, output op, output char_code, output cell_index, input ready);
	modport sink (input valid, input op, input char_code, input cell_index, output ready);
endinterface

interface tcw_rsp_if;
	logic                         valid;
	logic                         ready;
	logic [tcw_pkg::IDX_W-1:0]    cursor_pos;
	logic [tcw_pkg::CHAR_W-1:0]   cell_char;
	logic [tcw_pkg::ATTR_W-1:0]   cell_attr;
	logic                         scrolled;

	modport source (output valid, output cursor_pos, output cell_char, output cell_attr,
		output scrolled, input ready);
	modport sink (input valid, input cursor_pos, input cell_char, input cell_attr,
		input scrolled, output ready);
endinterface

FILE: rtl/tcw_ctrl.sv
// controller state machine: sequences clearing, put, read, scroll and result hand-off
module tcw_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	output logic           out_valid,
	input  logic           out_ready,
	output tcw_pkg::cmd_t  cmd,
	input  tcw_pkg::sts_t  sts
);

	tcw_pkg::state_t state_q, state_d;
	logic            out_valid_q;
	logic            out_free;

	assign out_free  = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= tcw_pkg::ST_CLEAR;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load_out)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			tcw_pkg::ST_CLEAR: begin
				cmd.clear_step = 1'b1;
				if (sts.clear_done)
					state_d = tcw_pkg::ST_IDLE;
			end
			tcw_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				cmd.take = in_valid;
				if (in_valid)
					state_d = tcw_pkg::ST_EXEC;
			end
			tcw_pkg::ST_EXEC: begin
				cmd.exec = 1'b1;
				state_d  = sts.scroll ? tcw_pkg::ST_COPY : tcw_pkg::ST_FIN;
			end
			tcw_pkg::ST_COPY: begin
				cmd.copy_step = 1'b1;
				if (sts.copy_done)
					state_d = tcw_pkg::ST_BLANK;
			end
			tcw_pkg::ST_BLANK: begin
				cmd.blank_step = 1'b1;
				if (sts.blank_done)
					state_d = tcw_pkg::ST_FIN;
			end
			tcw_pkg::ST_FIN: begin
				if (out_free) begin
					cmd.load_out = 1'b1;
					state_d      = tcw_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = tcw_pkg::ST_IDLE;
			end
		endcase
	end

`ifndef ASSERT_OFF
	// a put or read with no scroll goes straight to the result stage
	a_exec_to_fin: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == tcw_pkg::ST_EXEC && !sts.scroll |=> state_q == tcw_pkg::ST_FIN)
		else $error("exec without scroll did not finish");

	// a scroll always runs the copy pass first
	a_exec_to_copy: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == tcw_pkg::ST_EXEC && sts.scroll |=> state_q == tcw_pkg::ST_COPY)
		else $error("scroll did not start copy");

	// a result is never loaded over one still waiting
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !out_ready |-> !cmd.load_out)
		else $error("result overwritten");
`endif

endmodule

FILE: rtl/tcw_dp.sv
// datapath: screen store, cursor, configuration registers and result register
module tcw_dp #(
	parameter int COLS = tcw_pkg::SCREEN_COLUMNS,
	parameter int ROWS = tcw_pkg::SCREEN_ROWS
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  tcw_pkg::cmd_t                     cmd,
	output tcw_pkg::sts_t                     sts,
	input  logic                              cfg_we,
	input  logic [tcw_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [tcw_pkg::CFG_DATA_W-1:0]    cfg_wdata,
	input  logic                              op,
	input  logic [tcw_pkg::CHAR_W-1:0]        char_code,
	input  logic [tcw_pkg::IDX_W-1:0]         cell_index,
	output logic [tcw_pkg::IDX_W-1:0]         cursor_pos,
	output logic [tcw_pkg::CHAR_W-1:0]        cell_char,
	output logic [tcw_pkg::ATTR_W-1:0]        cell_attr,
	output logic                              scrolled
);

	localparam int CELLS  = COLS * ROWS;
	localparam int MOVED  = CELLS - COLS;
	localparam int ADDR_W = $clog2(CELLS);
	localparam int CNT_W  = $clog2(CELLS + 1);
	localparam int COL_W  = $clog2(COLS);
	localparam int ROW_W  = $clog2(ROWS);
	localparam int SUM_W  = tcw_pkg::TAB_W + 1;
	localparam int CMP_W  = 13;

	logic [tcw_pkg::CELL_W-1:0] mem [CELLS];
	logic [tcw_pkg::CELL_W-1:0] rdata_q;

	logic [tcw_pkg::ATTR_W-1:0] attr_q;
	logic [tcw_pkg::TAB_W-1:0]  tab_q;
	logic [COL_W-1:0]           col_q;
	logic [ROW_W-1:0]           row_q;
	logic [CNT_W-1:0]           cnt_q;
	logic                       pend_s1;
	logic [ADDR_W-1:0]          dst_s1;

	logic                       op_q;
	logic [tcw_pkg::CHAR_W-1:0] ch_q;
	logic [tcw_pkg::IDX_W-1:0]  idx_q;
	logic                       rd_ok_q;
	logic                       scrolled_q;

	logic                       is_read, is_tab, is_nl, wrap, last_row, copy_more, in_range;
	logic [SUM_W-1:0]           tab_sum, inc_sum, next_sum;
	logic [ADDR_W-1:0]          pos;

	logic                       we, re;
	logic [ADDR_W-1:0]          waddr, raddr;
	logic [tcw_pkg::CELL_W-1:0] wdata;

	assign is_read   = op_q == tcw_pkg::OP_READ;
	assign is_tab    = ch_q == tcw_pkg::CH_TAB;
	assign is_nl     = ch_q == tcw_pkg::CH_LF || ch_q == tcw_pkg::CH_CR;
	assign tab_sum   = SUM_W'(col_q) + SUM_W'(tab_q);
	assign inc_sum   = SUM_W'(col_q) + SUM_W'(1);
	assign next_sum  = is_tab ? tab_sum : inc_sum;
	assign wrap      = is_nl || next_sum >= SUM_W'(COLS);
	assign last_row  = row_q == ROW_W'(ROWS - 1);
	assign pos       = ADDR_W'(row_q * COLS + col_q);
	assign copy_more = cnt_q < CNT_W'(MOVED);
	assign in_range  = CMP_W'(idx_q) < CMP_W'(CELLS);

	assign sts.scroll     = !is_read && wrap && last_row;
	assign sts.clear_done = cnt_q == CNT_W'(CELLS - 1);
	assign sts.blank_done = cnt_q == CNT_W'(CELLS - 1);
	assign sts.copy_done  = !copy_more && pend_s1;

	// store port selection
	always_comb begin
		we    = 1'b0;
		re    = 1'b0;
		waddr = '0;
		raddr = '0;
		wdata = '0;
		if (cmd.clear_step) begin
			we    = 1'b1;
			waddr = cnt_q[ADDR_W-1:0];
			wdata = {tcw_pkg::RESET_ATTR, tcw_pkg::CH_NUL};
		end
		if (cmd.blank_step) begin
			we    = 1'b1;
			waddr = cnt_q[ADDR_W-1:0];
			wdata = {attr_q, tcw_pkg::CH_NUL};
		end
		if (cmd.copy_step) begin
			// read one row ahead, write the cell fetched last cycle
			we    = pend_s1;
			waddr = dst_s1;
			wdata = rdata_q;
			re    = copy_more;
			raddr = ADDR_W'(cnt_q + COLS);
		end
		if (cmd.exec) begin
			if (is_read) begin
				re    = in_range;
				raddr = ADDR_W'(idx_q);
			end else if (!is_tab && !is_nl) begin
				we    = 1'b1;
				waddr = pos;
				wdata = {attr_q, ch_q};
			end
		end
	end

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		if (re)
			rdata_q <= mem[raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			attr_q  <= tcw_pkg::RESET_ATTR;
			tab_q   <= tcw_pkg::RESET_TAB;
			col_q   <= '0;
			row_q   <= '0;
			cnt_q   <= '0;
			pend_s1 <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					tcw_pkg::REG_TEXT_ATTR:   attr_q <= cfg_wdata;
					tcw_pkg::REG_TAB_ADVANCE: tab_q  <= cfg_wdata[tcw_pkg::TAB_W-1:0];
					default: ;
				endcase
			end
			if (cmd.exec) begin
				cnt_q   <= '0;
				pend_s1 <= 1'b0;
				if (!is_read) begin
					if (wrap) begin
						col_q <= '0;
						if (!last_row)
							row_q <= row_q + ROW_W'(1);
					end else begin
						col_q <= COL_W'(next_sum);
					end
				end
			end
			if (cmd.clear_step || cmd.blank_step || (cmd.copy_step && copy_more))
				cnt_q <= cnt_q + CNT_W'(1);
			if (cmd.copy_step)
				pend_s1 <= copy_more;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.take) begin
			op_q  <= op;
			ch_q  <= char_code;
			idx_q <= cell_index;
		end
		if (cmd.exec) begin
			rd_ok_q    <= is_read && in_range;
			scrolled_q <= sts.scroll;
		end
		if (cmd.copy_step)
			dst_s1 <= cnt_q[ADDR_W-1:0];
		if (cmd.load_out) begin
			cursor_pos <= tcw_pkg::IDX_W'(pos);
			cell_char  <= rd_ok_q ? rdata_q[tcw_pkg::CHAR_W-1:0] : tcw_pkg::CH_NUL;
			cell_attr  <= rd_ok_q ? rdata_q[tcw_pkg::CELL_W-1:tcw_pkg::CHAR_W] : '0;
			scrolled   <= scrolled_q;
		end
	end

`ifndef ASSERT_OFF
	a_cursor_range: assert property (@(posedge clk) disable iff (!arst_n)
		CNT_W'(col_q) < CNT_W'(COLS) && CNT_W'(row_q) < CNT_W'(ROWS))
		else $error("cursor outside the screen");

	// blanking only touches the bottom row
	a_blank_row: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.blank_step |-> cnt_q >= CNT_W'(MOVED) && cnt_q < CNT_W'(CELLS))
		else $error("blank outside the bottom row");

	// copy writes stay above the bottom row and target the cell one behind the copy counter
	a_copy_dst: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.copy_step && pend_s1 |-> CNT_W'(dst_s1) < CNT_W'(MOVED)
			&& CNT_W'(dst_s1) + CNT_W'(1) == cnt_q)
		else $error("copy destination out of step");
`endif

endmodule

FILE: rtl/text_console_writer.sv
// text console writer top level: controller and datapath around the screen store
// Each request beat is either a put (one byte at the cursor; tab, LF and CR only move the
// cursor) or a read of one screen cell, and returns exactly one response beat with the cursor
// position after it. A put that scrolls first moves every cell up one row through the single
// read and single write port of the screen store, one cell per cycle, then blanks the bottom
// row with the current attribute. One request is in flight at a time; the next is taken as
// soon as the previous result sits in the output register. After reset the store is cleared
// to character 0 with attribute 7, one cell per cycle, during which no request is taken;
// configuration writes (0 text attribute, 1 tab advance) are taken at any time but belong
// between requests.
module text_console_writer #(
	parameter int SCREEN_COLUMNS = tcw_pkg::SCREEN_COLUMNS,
	parameter int SCREEN_ROWS    = tcw_pkg::SCREEN_ROWS
) (
	input  logic                            clk,
	input  logic                            arst_n,
	tcw_req_if.sink                         req,
	tcw_rsp_if.source                       rsp,
	input  logic                            cfg_we,
	input  logic [tcw_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [tcw_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

	tcw_pkg::cmd_t cmd;
	tcw_pkg::sts_t sts;

	tcw_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (req.valid),
		.in_ready  (req.ready),
		.out_valid (rsp.valid),
		.out_ready (rsp.ready),
		.cmd       (cmd),
		.sts       (sts)
	);

	tcw_dp #(
		.COLS (SCREEN_COLUMNS),
		.ROWS (SCREEN_ROWS)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.sts        (sts),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_wdata  (cfg_wdata),
		.op         (req.op),
		.char_code  (req.char_code),
		.cell_index (req.cell_index),
		.cursor_pos (rsp.cursor_pos),
		.cell_char  (rsp.cell_char),
		.cell_attr  (rsp.cell_attr),
		.scrolled   (rsp.scrolled)
	);

endmodule
